[src/ipru_pkg.sv]
// ----------------------------------------------------------------------------
// ipru_pkg
// Shared types, constants and helpers for the integer pixel replication
// upscaler.
// ----------------------------------------------------------------------------
package ipru_pkg;

   localparam int MAX_WIDTH_DEF = 1024;
   localparam int MAX_SCALE_DEF = 8;

   localparam int PIXEL_W     = 24;
   localparam int SCALE_W     = 4;
   localparam int WIDTH_W     = 11;
   localparam int KIND_W      = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 11;
   localparam int RSP_USER_W  = 3;

   typedef enum logic [KIND_W-1:0] {
      KIND_PIXEL   = 2'd0,
      KIND_PAD     = 2'd1,
      KIND_REFUSED = 2'd2
   } kind_type;

   typedef enum logic {
      CMD_PUSH    = 1'b0,
      CMD_ADVANCE = 1'b1
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SCALE = 1'b0,
      CSR_WIDTH = 1'b1
   } csr_index_type;

   // Per-word control handed from the row controller to the emitter.
   typedef struct packed {
      logic       refused;
      logic       from_mem;
      logic       row_done;
      logic [1:0] pad;
   } desc_type;

   // An output row holds width * scale * 3 bytes; the pad up to a multiple of
   // four works out to (width * scale) mod 4, so only the low bits matter.
   function automatic logic [1:0] pad_bytes(input logic [1:0] width_lo,
                                            input logic [1:0] scale_lo);
      logic [3:0] prod;
      prod = width_lo * scale_lo;
      return prod[1:0];
   endfunction

endpackage

[src/ipru_line_store.sv]
// ----------------------------------------------------------------------------
// ipru_line_store
// Single-port line buffer with a registered read port.
// ----------------------------------------------------------------------------
module ipru_line_store #(
   parameter int DEPTH  = ipru_pkg::MAX_WIDTH_DEF,
   parameter int ADDR_W = 10
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic                         rd_en,
   input  logic [ADDR_W-1:0]            addr,
   input  logic [ipru_pkg::PIXEL_W-1:0] wdata,
   output logic [ipru_pkg::PIXEL_W-1:0] rdata
);

   logic [ipru_pkg::PIXEL_W-1:0] mem [DEPTH];
   logic [ipru_pkg::PIXEL_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[src/ipru_ctrl.sv]
// ----------------------------------------------------------------------------
// ipru_ctrl
// Row controller: tracks the write and replay columns, issues the line buffer
// access and builds the per-word descriptor.
// ----------------------------------------------------------------------------
module ipru_ctrl #(
   parameter int COL_W  = 10,
   parameter int WID_W  = 11,
   parameter int CNT_W  = 4,
   parameter int COPY_W = 3
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic                         cmd,
   input  logic [ipru_pkg::PIXEL_W-1:0] pixel_in,
   input  logic [WID_W-1:0]             eff_width,
   input  logic [CNT_W-1:0]             eff_scale,
   output logic                         mem_wr,
   output logic                         mem_rd,
   output logic [COL_W-1:0]             mem_addr,
   output logic [ipru_pkg::PIXEL_W-1:0] mem_wdata,
   output ipru_pkg::desc_type           desc
);

   logic [COL_W-1:0]  write_column_ff, write_column_in;
   logic [COL_W-1:0]  replay_column_ff, replay_column_in;
   logic [COPY_W-1:0] copies_left_ff, copies_left_in;
   logic              replaying_ff, replaying_in;

   logic       push_done;
   logic       replay_done;
   logic [1:0] row_pad;

   assign push_done   = (32'(write_column_ff) + 32'd1) >= 32'(eff_width);
   assign replay_done = (32'(replay_column_ff) + 32'd1) >= 32'(eff_width);
   assign row_pad     = ipru_pkg::pad_bytes(2'(eff_width), 2'(eff_scale));
   assign mem_wdata   = pixel_in;

   always_comb begin
      write_column_in  = write_column_ff;
      replay_column_in = replay_column_ff;
      copies_left_in   = copies_left_ff;
      replaying_in     = replaying_ff;
      mem_wr           = 1'b0;
      mem_rd           = 1'b0;
      mem_addr         = write_column_ff;
      desc             = '0;

      if (cmd == ipru_pkg::CMD_PUSH) begin
         if (replaying_ff) begin
            desc.refused = 1'b1;
         end else begin
            mem_wr        = accept;
            desc.row_done = push_done;
            desc.pad      = push_done ? row_pad : 2'd0;
            if (accept) begin
               if (push_done) begin
                  write_column_in = '0;
                  if (eff_scale > CNT_W'(1)) begin
                     replaying_in     = 1'b1;
                     copies_left_in   = COPY_W'(32'(eff_scale) - 32'd1);
                     replay_column_in = '0;
                  end
               end else begin
                  write_column_in = write_column_ff + COL_W'(1);
               end
            end
         end
      end else begin
         if (!replaying_ff) begin
            desc.refused = 1'b1;
         end else begin
            mem_rd        = accept;
            mem_addr      = replay_column_ff;
            desc.from_mem = 1'b1;
            desc.row_done = replay_done;
            desc.pad      = replay_done ? row_pad : 2'd0;
            if (accept) begin
               if (replay_done) begin
                  replay_column_in = '0;
                  copies_left_in   = copies_left_ff - COPY_W'(1);
                  if (copies_left_ff == COPY_W'(1)) begin
                     replaying_in = 1'b0;
                  end
               end else begin
                  replay_column_in = replay_column_ff + COL_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_column_ff  <= '0;
         replay_column_ff <= '0;
         copies_left_ff   <= '0;
         replaying_ff     <= 1'b0;
      end else begin
         write_column_ff  <= write_column_in;
         replay_column_ff <= replay_column_in;
         copies_left_ff   <= copies_left_in;
         replaying_ff     <= replaying_in;
      end
   end

   a_replay_has_copies : assert property (@(posedge clock) disable iff (reset)
      replaying_ff |-> copies_left_ff != '0)
      else $error("replay active with no copies left");

   a_replay_write_idle : assert property (@(posedge clock) disable iff (reset)
      replaying_ff |-> write_column_ff == '0)
      else $error("write column moved during replay");

   a_refused_no_access : assert property (@(posedge clock) disable iff (reset)
      desc.refused |-> !mem_wr && !mem_rd)
      else $error("refused word touched the line buffer");

endmodule

[src/ipru_emit.sv]
// ----------------------------------------------------------------------------
// ipru_emit
// Two-stage result emitter: a holding stage for the accepted word and an
// output stage that steps through pixel copies and pad bytes.
// ----------------------------------------------------------------------------
module ipru_emit #(
   parameter int CNT_W = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  ipru_pkg::desc_type           desc_in,
   input  logic [ipru_pkg::PIXEL_W-1:0] pixel_in,
   input  logic [CNT_W-1:0]             count_in,
   input  logic [ipru_pkg::PIXEL_W-1:0] mem_rdata,
   output logic                         ready,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output ipru_pkg::kind_type           kind,
   output logic [ipru_pkg::PIXEL_W-1:0] pixel_out,
   output logic                         row_end,
   output logic                         last
);

   logic                         s1_valid_ff;
   ipru_pkg::desc_type           s1_desc_ff;
   logic [ipru_pkg::PIXEL_W-1:0] s1_pixel_ff;
   logic [CNT_W-1:0]             s1_count_ff;

   logic                         s2_valid_ff;
   logic                         s2_refused_ff;
   logic                         s2_row_done_ff;
   logic [ipru_pkg::PIXEL_W-1:0] s2_pixel_ff;
   logic [CNT_W-1:0]             s2_pix_left_ff;
   logic [1:0]                   s2_pad_left_ff;

   logic s2_take;
   logic s2_free;
   logic s1_move;

   always_comb begin
      if (s2_refused_ff) begin
         kind      = ipru_pkg::KIND_REFUSED;
         pixel_out = '0;
         last      = 1'b1;
         row_end   = 1'b0;
      end else if (s2_pix_left_ff != '0) begin
         kind      = ipru_pkg::KIND_PIXEL;
         pixel_out = s2_pixel_ff;
         last      = (s2_pix_left_ff == CNT_W'(1)) && (s2_pad_left_ff == 2'd0);
         row_end   = last && s2_row_done_ff;
      end else begin
         kind      = ipru_pkg::KIND_PAD;
         pixel_out = '0;
         last      = s2_pad_left_ff == 2'd1;
         row_end   = last;
      end
   end

   assign rsp_valid = s2_valid_ff;
   assign s2_take   = s2_valid_ff && rsp_ready;
   assign s2_free   = !s2_valid_ff || (s2_take && last);
   assign s1_move   = s1_valid_ff && s2_free;
   assign ready     = !s1_valid_ff || s2_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (load) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_desc_ff  <= desc_in;
         s1_pixel_ff <= pixel_in;
         s1_count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_move) begin
         s2_valid_ff <= 1'b1;
      end else if (s2_take && last) begin
         s2_valid_ff <= 1'b0;
      end
   end

   // The line buffer read data stays put until the next accepted replay word,
   // which cannot land before the holding stage has moved on.
   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_refused_ff  <= s1_desc_ff.refused;
         s2_row_done_ff <= s1_desc_ff.row_done;
         s2_pad_left_ff <= s1_desc_ff.pad;
         s2_pix_left_ff <= s1_count_ff;
         s2_pixel_ff    <= s1_desc_ff.from_mem ? mem_rdata : s1_pixel_ff;
      end else if (s2_take && !last) begin
         if (s2_pix_left_ff != '0) begin
            s2_pix_left_ff <= s2_pix_left_ff - CNT_W'(1);
         end else begin
            s2_pad_left_ff <= s2_pad_left_ff - 2'd1;
         end
      end
   end

   a_pad_only_at_row_end : assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s2_refused_ff && s2_pad_left_ff != 2'd0 |-> s2_row_done_ff)
      else $error("pad bytes queued for a row that does not end");

   a_row_end_is_last : assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && row_end |-> last)
      else $error("row end not on the last word of an item");

   a_hold_waits : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_free |=> s1_valid_ff)
      else $error("holding stage dropped a word while the output was busy");

endmodule

[src/integer_pixel_replication_upscaler.sv]
// ----------------------------------------------------------------------------
// integer_pixel_replication_upscaler
// Nearest-neighbor integer upscaler for 24-bit pixel rows with a line buffer
// for row replay and zero padding of each output row to a multiple of four bytes.
// ----------------------------------------------------------------------------
//
//   channel  direction  tdata / payload             tuser / tlast
//   req_     in         [23:0] pixel_in             tuser[0] cmd
//   rsp_     out        [23:0] pixel_out            tuser[1:0] kind, tuser[2] last;
//                                                   tlast row_end
//   csr_     in         index 0 scale, 1 width      data [10:0]
//
// Each accepted word yields scale pixel words, plus zero to three pad bytes at
// the end of a row, one result word per cycle while rsp_tready is high; a
// refused word yields one. The first result passes the holding stage and the
// line buffer read first, then the output stage. A holding stage lets the
// next input word be taken while the output stage still works, so words
// follow back to back.
// Reset is synchronous and active high; the line buffer is not cleared.
// Stalls on rsp_tready hold the current result and back up into req_tready
// once the holding stage is full.
// ----------------------------------------------------------------------------
module integer_pixel_replication_upscaler #(
   parameter int MAX_WIDTH = ipru_pkg::MAX_WIDTH_DEF,
   parameter int MAX_SCALE = ipru_pkg::MAX_SCALE_DEF
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ipru_pkg::PIXEL_W-1:0]     req_tdata,   // [23:0] pixel_in
   input  logic                             req_tuser,   // [0] cmd

   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ipru_pkg::PIXEL_W-1:0]     rsp_tdata,   // [23:0] pixel_out
   output logic [ipru_pkg::RSP_USER_W-1:0]  rsp_tuser,   // [1:0] kind, [2] last
   output logic                             rsp_tlast,   // row_end

   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ipru_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ipru_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WID_W  = $clog2(MAX_WIDTH + 1);
   localparam int CNT_W  = $clog2(MAX_SCALE + 1);
   localparam int COPY_W = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

   // Configuration registers; the port always takes a write.
   logic [ipru_pkg::SCALE_W-1:0] scale_ff;
   logic [ipru_pkg::WIDTH_W-1:0] width_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= ipru_pkg::SCALE_W'(1);
         width_ff <= ipru_pkg::WIDTH_W'(1);
      end else if (csr_valid) begin
         case (csr_index)
            ipru_pkg::CSR_SCALE: scale_ff <= csr_data[ipru_pkg::SCALE_W-1:0];
            ipru_pkg::CSR_WIDTH: width_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Zero means one and anything above the build limit saturates.
   logic [CNT_W-1:0] eff_scale;
   logic [WID_W-1:0] eff_width;

   always_comb begin
      if (scale_ff == '0) begin
         eff_scale = CNT_W'(1);
      end else if (32'(scale_ff) > 32'(MAX_SCALE)) begin
         eff_scale = CNT_W'(MAX_SCALE);
      end else begin
         eff_scale = CNT_W'(scale_ff);
      end

      if (width_ff == '0) begin
         eff_width = WID_W'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         eff_width = WID_W'(MAX_WIDTH);
      end else begin
         eff_width = WID_W'(width_ff);
      end
   end

   logic                         accept;
   logic                         mem_wr;
   logic                         mem_rd;
   logic [COL_W-1:0]             mem_addr;
   logic [ipru_pkg::PIXEL_W-1:0] mem_wdata;
   logic [ipru_pkg::PIXEL_W-1:0] mem_rdata;
   ipru_pkg::desc_type           desc;
   ipru_pkg::kind_type           rsp_kind;
   logic                         rsp_last;

   assign accept = req_tvalid && req_tready;

   // Row state and line buffer address for the word at the input.
   ipru_ctrl #(
      .COL_W  (COL_W),
      .WID_W  (WID_W),
      .CNT_W  (CNT_W),
      .COPY_W (COPY_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .cmd       (req_tuser),
      .pixel_in  (req_tdata),
      .eff_width (eff_width),
      .eff_scale (eff_scale),
      .mem_wr    (mem_wr),
      .mem_rd    (mem_rd),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .desc      (desc)
   );

   // Pushes write the source pixel; replay words read it back through the registered read port.
   ipru_line_store #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (COL_W)
   ) u_line_store (
      .clock (clock),
      .wr_en (mem_wr),
      .rd_en (mem_rd),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   ipru_emit #(
      .CNT_W (CNT_W)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .desc_in   (desc),
      .pixel_in  (req_tdata),
      .count_in  (eff_scale),
      .mem_rdata (mem_rdata),
      .ready     (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .kind      (rsp_kind),
      .pixel_out (rsp_tdata),
      .row_end   (rsp_tlast),
      .last      (rsp_last)
   );

   assign rsp_tuser = {rsp_last, rsp_kind};

endmodule
